>>> rtl/xbm_pkg.sv
`default_nettype none

package xbm_pkg;

    localparam int CHAR_W       = 8;
    localparam int DIM_W        = 12;
    localparam int ROW_POS_W    = 10;
    localparam int TOKEN_W      = 16;
    localparam int CFG_INDEX_W  = 2;
    localparam int CFG_DATA_W   = 12;
    localparam int FIFO_DEPTH   = 4;
    localparam int FIFO_PTR_W   = $clog2(FIFO_DEPTH);
    localparam int FIFO_CNT_W   = $clog2(FIFO_DEPTH + 1);

    localparam logic [DIM_W-1:0] WIDTH_RESET  = 12'd16;
    localparam logic [DIM_W-1:0] HEIGHT_RESET = 12'd16;

    // character codes
    localparam logic [CHAR_W-1:0] CHR_DIGIT_0 = 8'h30;
    localparam logic [CHAR_W-1:0] CHR_DIGIT_9 = 8'h39;
    localparam logic [CHAR_W-1:0] CHR_UPPER_A = 8'h41;
    localparam logic [CHAR_W-1:0] CHR_UPPER_F = 8'h46;
    localparam logic [CHAR_W-1:0] CHR_LOWER_A = 8'h61;
    localparam logic [CHAR_W-1:0] CHR_LOWER_F = 8'h66;
    localparam logic [CHAR_W-1:0] CHR_SPACE   = 8'h20;
    localparam logic [CHAR_W-1:0] CHR_COMMA   = 8'h2c;
    localparam logic [CHAR_W-1:0] CHR_RBRACE  = 8'h7d;
    localparam logic [CHAR_W-1:0] CHR_NEWLINE = 8'h0a;
    localparam logic [CHAR_W-1:0] CHR_TAB     = 8'h09;
    localparam logic [CHAR_W-1:0] HEX_ALPHA_OFFSET = 8'd10;

    typedef enum logic [CFG_INDEX_W-1:0] {
        CFG_IMAGE_WIDTH     = 2'd0,
        CFG_IMAGE_HEIGHT    = 2'd1,
        CFG_OLD_WORD_FORMAT = 2'd2
    } cfg_index_t;

    typedef struct packed {
        logic [CHAR_W-1:0] pixel_byte;
        logic              last_byte;
        logic              truncated;
    } result_t;

    // up to two results produced by one transfer
    typedef struct packed {
        logic [1:0] num;
        result_t    first;
        result_t    second;
    } result_pair_t;

    typedef struct packed {
        logic not_empty;
        logic room_for_two;
    } fifo_status_t;

    function automatic logic is_hex_char(input logic [CHAR_W-1:0] c);
        is_hex_char = ((c >= CHR_DIGIT_0) && (c <= CHR_DIGIT_9))
                   || ((c >= CHR_UPPER_A) && (c <= CHR_UPPER_F))
                   || ((c >= CHR_LOWER_A) && (c <= CHR_LOWER_F));
    endfunction

    function automatic logic [3:0] hex_value(input logic [CHAR_W-1:0] c);
        logic [CHAR_W-1:0] v;
        if ((c >= CHR_DIGIT_0) && (c <= CHR_DIGIT_9))
        begin
            v = c - CHR_DIGIT_0;
        end
        else if ((c >= CHR_UPPER_A) && (c <= CHR_UPPER_F))
        begin
            v = c - CHR_UPPER_A + HEX_ALPHA_OFFSET;
        end
        else
        begin
            v = c - CHR_LOWER_A + HEX_ALPHA_OFFSET;
        end
        hex_value = v[3:0];
    endfunction

    function automatic logic is_delimiter(input logic [CHAR_W-1:0] c);
        case (c) inside
            CHR_SPACE, CHR_COMMA, CHR_RBRACE, CHR_NEWLINE, CHR_TAB: is_delimiter = 1'b1;
            default: is_delimiter = 1'b0;
        endcase
    endfunction

endpackage

`default_nettype wire

>>> rtl/xbm_char_if.sv
`default_nettype none

interface xbm_char_if
    import xbm_pkg::*;
();
    logic              valid;
    logic              ready;
    logic [CHAR_W-1:0] char_code;
    logic              end_of_file;

    modport source (output valid, output char_code, output end_of_file, input ready);
    modport sink   (input valid, input char_code, input end_of_file, output ready);
endinterface

`default_nettype wire

>>> rtl/xbm_byte_if.sv
`default_nettype none

interface xbm_byte_if
    import xbm_pkg::*;
();
    logic              valid;
    logic              ready;
    logic [CHAR_W-1:0] pixel_byte;
    logic              last_byte;
    logic              truncated;

    modport source (output valid, output pixel_byte, output last_byte, output truncated,
                    input ready);
    modport sink   (input valid, input pixel_byte, input last_byte, input truncated,
                    output ready);
endinterface

`default_nettype wire

>>> rtl/xbm_bitmap_body_decoder_unit.sv
// channel    dir  payload                               transfer
// char_in    in   char_code[7:0], end_of_file           valid & ready
// byte_out   out  pixel_byte[7:0], last_byte, truncated valid & ready
// cfg        in   cfg_index[1:0], cfg_data[11:0]        cfg_write_enable
//
// one character is taken per cycle while the queue has room for two; its bytes are in the result queue the next cycle
// an x10 word puts up to two bytes into the queue at once, while byte_out.ready is high the output drains one per cycle
// char_in.ready drops only when the four-entry result queue has room for fewer than two
// reset sets width and height to 16, x11 format, and clears token, counters and queue
`default_nettype none

module xbm_bitmap_body_decoder_unit
    import xbm_pkg::*;
(
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    xbm_char_if.sink                    char_in,
    xbm_byte_if.source                  byte_out,
    input  wire logic                   cfg_write_enable,
    input  wire logic [CFG_INDEX_W-1:0] cfg_index,
    input  wire logic [CFG_DATA_W-1:0]  cfg_data
);

    // configuration
    logic [DIM_W-1:0]     width_reg;
    logic [DIM_W-1:0]     width_next;
    logic [DIM_W-1:0]     height_reg;
    logic [DIM_W-1:0]     height_next;
    logic                 old_format_reg;
    logic                 old_format_next;

    // parse state
    logic [TOKEN_W-1:0]   token_reg;
    logic [TOKEN_W-1:0]   token_next;
    logic                 has_digit_reg;
    logic                 has_digit_next;
    logic [ROW_POS_W-1:0] row_pos_reg;
    logic [ROW_POS_W-1:0] row_pos_next;
    logic [DIM_W-1:0]     row_count_reg;
    logic [DIM_W-1:0]     row_count_next;
    logic                 done_reg;
    logic                 done_next;

    logic                 accept;
    logic                 dims_ok;
    logic [DIM_W:0]       width_round;
    logic [ROW_POS_W-1:0] row_len;
    logic [ROW_POS_W-1:0] pos1;
    logic [ROW_POS_W-1:0] pos2;
    logic                 wrap1;
    logic                 wrap2;
    logic [DIM_W-1:0]     rows_plus1;
    logic                 image_end;

    result_pair_t         push;
    fifo_status_t         status;
    result_t              head;

    assign accept = char_in.valid && char_in.ready;

    // bytes per row is ceil(width / 8)
    assign width_round = {1'b0, width_reg} + (DIM_W + 1)'(7);
    assign row_len     = width_round[DIM_W:3];
    assign dims_ok     = (width_reg != '0) && (height_reg != '0);

    // byte counter advance for the first and (x10 only) second byte of a token
    assign pos1       = row_pos_reg + ROW_POS_W'(1);
    assign wrap1      = (pos1 >= row_len);
    assign pos2       = pos1 + ROW_POS_W'(1);
    assign wrap2      = (pos2 >= row_len);
    assign rows_plus1 = row_count_reg + DIM_W'(1);
    assign image_end  = (rows_plus1 >= height_reg);

    always_comb
    begin
        width_next      = width_reg;
        height_next     = height_reg;
        old_format_next = old_format_reg;
        token_next      = token_reg;
        has_digit_next  = has_digit_reg;
        row_pos_next    = row_pos_reg;
        row_count_next  = row_count_reg;
        done_next       = done_reg;
        push            = '0;

        if (accept && !done_reg)
        begin
            if (char_in.end_of_file)
            begin
                // early end of input: one error result, partial token dropped
                done_next              = 1'b1;
                token_next             = '0;
                has_digit_next         = 1'b0;
                push.num               = 2'd1;
                push.first.truncated   = 1'b1;
            end
            else if (is_hex_char(char_in.char_code))
            begin
                token_next     = {token_reg[TOKEN_W-5:0], hex_value(char_in.char_code)};
                has_digit_next = 1'b1;
            end
            else if (is_delimiter(char_in.char_code) && has_digit_reg)
            begin
                token_next     = '0;
                has_digit_next = 1'b0;
                if (dims_ok)
                begin
                    push.first.pixel_byte = token_reg[7:0];
                    push.first.last_byte  = wrap1 && image_end;
                    if (wrap1)
                    begin
                        // row complete; in x10 mode the padding high byte is dropped
                        push.num       = 2'd1;
                        row_pos_next   = '0;
                        row_count_next = rows_plus1;
                        done_next      = image_end;
                    end
                    else if (old_format_reg)
                    begin
                        push.num               = 2'd2;
                        push.second.pixel_byte = token_reg[15:8];
                        push.second.last_byte  = wrap2 && image_end;
                        row_pos_next           = wrap2 ? '0 : pos2;
                        row_count_next         = wrap2 ? rows_plus1 : row_count_reg;
                        done_next              = wrap2 && image_end;
                    end
                    else
                    begin
                        push.num     = 2'd1;
                        row_pos_next = pos1;
                    end
                end
            end
        end

        // any write to a defined register (index 0 to 2) restarts parsing
        if (cfg_write_enable)
        begin
            unique case (cfg_index_t'(cfg_index))
                CFG_IMAGE_WIDTH:
                begin
                    width_next = cfg_data[DIM_W-1:0];
                end
                CFG_IMAGE_HEIGHT:
                begin
                    height_next = cfg_data[DIM_W-1:0];
                end
                CFG_OLD_WORD_FORMAT:
                begin
                    old_format_next = cfg_data[0];
                end
                default:
                begin
                end
            endcase
            if (cfg_index <= CFG_INDEX_W'(CFG_OLD_WORD_FORMAT))
            begin
                token_next     = '0;
                has_digit_next = 1'b0;
                row_pos_next   = '0;
                row_count_next = '0;
                done_next      = 1'b0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_reg      <= WIDTH_RESET;
            height_reg     <= HEIGHT_RESET;
            old_format_reg <= 1'b0;
            token_reg      <= '0;
            has_digit_reg  <= 1'b0;
            row_pos_reg    <= '0;
            row_count_reg  <= '0;
            done_reg       <= 1'b0;
        end
        else
        begin
            width_reg      <= width_next;
            height_reg     <= height_next;
            old_format_reg <= old_format_next;
            token_reg      <= token_next;
            has_digit_reg  <= has_digit_next;
            row_pos_reg    <= row_pos_next;
            row_count_reg  <= row_count_next;
            done_reg       <= done_next;
        end
    end

    // result queue parts the input side from output stalls
    xbm_result_fifo u_result_fifo
    (
        .clk    (clk),
        .rst_n  (rst_n),
        .push   (push),
        .pop    (byte_out.valid && byte_out.ready),
        .head   (head),
        .status (status)
    );

    // characters after completion are still taken and dropped
    assign char_in.ready       = status.room_for_two;
    assign byte_out.valid      = status.not_empty;
    assign byte_out.pixel_byte = head.pixel_byte;
    assign byte_out.last_byte  = head.last_byte;
    assign byte_out.truncated  = head.truncated;

endmodule

`default_nettype wire

>>> rtl/xbm_result_fifo.sv
`default_nettype none

module xbm_result_fifo
    import xbm_pkg::*;
(
    input  wire logic         clk,
    input  wire logic         rst_n,
    input  wire result_pair_t push,
    input  wire logic         pop,
    output result_t           head,
    output fifo_status_t      status
);

    result_t                mem [FIFO_DEPTH];
    logic [FIFO_PTR_W-1:0]  wr_ptr_reg;
    logic [FIFO_PTR_W-1:0]  wr_ptr_next;
    logic [FIFO_PTR_W-1:0]  rd_ptr_reg;
    logic [FIFO_PTR_W-1:0]  rd_ptr_next;
    logic [FIFO_CNT_W-1:0]  count_reg;
    logic [FIFO_CNT_W-1:0]  count_next;
    logic [FIFO_PTR_W-1:0]  wr_ptr_plus1;

    assign wr_ptr_plus1 = wr_ptr_reg + FIFO_PTR_W'(1);

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg + FIFO_PTR_W'(push.num);
        rd_ptr_next = rd_ptr_reg + FIFO_PTR_W'(pop);
        count_next  = count_reg + FIFO_CNT_W'(push.num) - FIFO_CNT_W'(pop);
    end

    always_ff @(posedge clk)
    begin
        if (push.num != 2'd0)
        begin
            mem[wr_ptr_reg] <= push.first;
        end
        if (push.num == 2'd2)
        begin
            mem[wr_ptr_plus1] <= push.second;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    assign head                = mem[rd_ptr_reg];
    assign status.not_empty    = (count_reg != '0);
    assign status.room_for_two = (count_reg <= FIFO_CNT_W'(FIFO_DEPTH - 2));

endmodule

`default_nettype wire

>>> verif/tb.sv
`default_nettype none

module tb;
    import xbm_pkg::*;

    // stimulus volume and timing limits
    localparam int RANDOM_ITEMS   = 900;
    localparam int SETTLE_CYCLES  = 8;
    localparam int WATCHDOG_LIMIT = 2000;
    localparam int REPORT_LIMIT   = 10;

    // carriage return is skipped by the block, not a delimiter
    localparam logic [CHAR_W-1:0] CHR_CR = 8'h0d;

    // one entry of the character stream; a pause entry holds the sender
    // until every pending byte has come back
    typedef struct {
        logic [CHAR_W-1:0] code;
        logic              eof;
        bit                pause;
    } char_item_t;

    logic                   clk;
    logic                   rst_n;
    logic                   cfg_write_enable;
    logic [CFG_INDEX_W-1:0] cfg_index;
    logic [CFG_DATA_W-1:0]  cfg_data;

    xbm_char_if char_bus ();
    xbm_byte_if byte_bus ();

    xbm_bitmap_body_decoder_unit dut (
        .clk              (clk),
        .rst_n            (rst_n),
        .char_in          (char_bus),
        .byte_out         (byte_bus),
        .cfg_write_enable (cfg_write_enable),
        .cfg_index        (cfg_index),
        .cfg_data         (cfg_data)
    );

    // character stream waiting for the driver, bytes waiting for the monitor
    char_item_t char_stream[$];
    result_t    expected_bytes[$];
    char_item_t next_char;

    // decoder copy: image setup
    logic [DIM_W-1:0] img_width;
    logic [DIM_W-1:0] img_height;
    logic             x10_mode;

    // decoder copy: parse and progress state
    logic [TOKEN_W-1:0] tok;
    bit                 tok_has_digit;
    int                 row_pos;
    int                 rows_done;
    bit                 img_done;

    // handshake pacing
    int send_gap;
    int recv_stall;
    bit draining;
    bit steady_send;
    bit steady_recv;

    // bookkeeping
    int items_queued;
    int chars_taken;
    int bytes_checked;
    int lasts_seen;
    int truncs_seen;
    int image_setups;
    int mismatches;
    int idle_cycles;

    always
    begin
        clk = 1'b0;
        #5;
        clk = 1'b1;
        #5;
    end

    // ------------------------------------------------------------------
    // decoder prediction
    // ------------------------------------------------------------------

    function automatic void restart_image();
        tok           = '0;
        tok_has_digit = 1'b0;
        row_pos       = 0;
        rows_done     = 0;
        img_done      = 1'b0;
    endfunction

    function automatic void set_image_setup(input logic [DIM_W-1:0] w,
                                            input logic [DIM_W-1:0] h,
                                            input logic fmt);
        img_width  = w;
        img_height = h;
        x10_mode   = fmt;
        restart_image();
    endfunction

    // -1 for anything that is not a hex digit
    function automatic int hex_digit(input logic [CHAR_W-1:0] c);
        if (c >= CHR_DIGIT_0 && c <= CHR_DIGIT_9)
        begin
            return int'(c - CHR_DIGIT_0);
        end
        if (c >= CHR_UPPER_A && c <= CHR_UPPER_F)
        begin
            return int'(c - CHR_UPPER_A) + 10;
        end
        if (c >= CHR_LOWER_A && c <= CHR_LOWER_F)
        begin
            return int'(c - CHR_LOWER_A) + 10;
        end
        return -1;
    endfunction

    function automatic bit ends_token(input logic [CHAR_W-1:0] c);
        return c == CHR_SPACE || c == CHR_COMMA || c == CHR_RBRACE
            || c == CHR_NEWLINE || c == CHR_TAB;
    endfunction

    // one bitmap byte; advances row and image progress
    function automatic void emit_pixel(input logic [7:0] value);
        int   row_len;
        logic is_last;
        row_len = (int'(img_width) + 7) / 8;
        is_last = 1'b0;
        row_pos++;
        if (row_pos >= row_len)
        begin
            row_pos = 0;
            rows_done++;
            if (rows_done >= int'(img_height))
            begin
                is_last  = 1'b1;
                img_done = 1'b1;
            end
        end
        expected_bytes.push_back('{pixel_byte: value, last_byte: is_last, truncated: 1'b0});
    endfunction

    // expected bytes for one accepted character transfer
    function automatic void decode_char(input logic [CHAR_W-1:0] c, input logic eof);
        int                 d;
        logic [TOKEN_W-1:0] word;
        if (img_done)
        begin
            return;
        end
        // end of file: partial token dropped, one truncated result
        if (eof)
        begin
            img_done      = 1'b1;
            tok           = '0;
            tok_has_digit = 1'b0;
            expected_bytes.push_back('{pixel_byte: 8'h00, last_byte: 1'b0, truncated: 1'b1});
            return;
        end
        d = hex_digit(c);
        if (d >= 0)
        begin
            // long tokens keep only the low 16 bits
            tok           = {tok[TOKEN_W-5:0], 4'(d)};
            tok_has_digit = 1'b1;
            return;
        end
        if (!ends_token(c) || !tok_has_digit)
        begin
            return;
        end
        word          = tok;
        tok           = '0;
        tok_has_digit = 1'b0;
        // zero width or height never gives a byte
        if (img_width == '0 || img_height == '0)
        begin
            return;
        end
        emit_pixel(word[7:0]);
        // x10 high byte, dropped when the low byte closed a padded row
        if (x10_mode && !img_done && row_pos != 0)
        begin
            emit_pixel(word[15:8]);
        end
    endfunction

    // ------------------------------------------------------------------
    // stimulus building
    // ------------------------------------------------------------------

    function automatic void push_char(input logic [CHAR_W-1:0] c);
        char_stream.push_back('{code: c, eof: 1'b0, pause: 1'b0});
        items_queued++;
    endfunction

    // char_code is random under an end of file, the block must ignore it
    function automatic void push_eof();
        logic [CHAR_W-1:0] junk;
        junk = CHAR_W'($urandom_range(0, 255));
        char_stream.push_back('{code: junk, eof: 1'b1, pause: 1'b0});
        items_queued++;
    endfunction

    function automatic void push_pause();
        char_stream.push_back('{code: '0, eof: 1'b0, pause: 1'b1});
    endfunction

    function automatic void add_text(input string s);
        foreach (s[i])
        begin
            push_char(s[i]);
        end
    endfunction

    function automatic logic [CHAR_W-1:0] hex_char(input logic [3:0] nib);
        if (nib < 4'd10)
        begin
            return CHR_DIGIT_0 + nib;
        end
        if ($urandom_range(0, 1) == 1)
        begin
            return CHR_UPPER_A + (nib - 4'd10);
        end
        return CHR_LOWER_A + (nib - 4'd10);
    endfunction

    function automatic void add_delimiter();
        case ($urandom_range(0, 9))
            0: push_char(CHR_NEWLINE);
            1: push_char(CHR_TAB);
            2: push_char(CHR_SPACE);
            3:
            begin
                push_char(CHR_CR);
                push_char(CHR_NEWLINE);
            end
            4:
            begin
                push_char(CHR_COMMA);
                push_char(CHR_NEWLINE);
            end
            5: push_char(CHR_RBRACE);
            default:
            begin
                push_char(CHR_COMMA);
                push_char(CHR_SPACE);
            end
        endcase
    endfunction

    // stray character between tokens: skipped ones half the time, any code otherwise
    function automatic void add_noise();
        logic [CHAR_W-1:0] any_code;
        any_code = CHAR_W'($urandom_range(0, 255));
        case ($urandom_range(0, 3))
            0: push_char(CHR_CR);
            1: push_char("x");
            default: push_char(any_code);
        endcase
    endfunction

    function automatic void add_token(input int ndig);
        int prefix;
        prefix = $urandom_range(0, 9);
        if (prefix < 6)
        begin
            add_text("0x");
        end
        else if (prefix < 8)
        begin
            add_text("0X");
        end
        repeat (ndig)
        begin
            push_char(hex_char(4'($urandom_range(0, 15))));
        end
        add_delimiter();
    endfunction

    // bits[] body with ntok tokens; short bodies end in an end of file
    function automatic void add_body(input int ntok, input int base_digits,
                                     input bit cut_short, input bit trailing);
        int ndig;
        int pause_at;
        pause_at = ($urandom_range(0, 2) == 0) ? $urandom_range(0, ntok) : -1;
        add_text("{");
        push_char(CHR_NEWLINE);
        for (int t = 0; t < ntok; t++)
        begin
            if (t == pause_at)
            begin
                push_pause();
            end
            if ($urandom_range(0, 11) == 0)
            begin
                add_noise();
            end
            ndig = ($urandom_range(0, 9) == 0) ? $urandom_range(1, 6) : base_digits;
            add_token(ndig);
        end
        if (cut_short)
        begin
            // sometimes the file ends inside a token
            if ($urandom_range(0, 1) == 1)
            begin
                repeat ($urandom_range(1, 3))
                begin
                    push_char(hex_char(4'($urandom_range(0, 15))));
                end
            end
            push_eof();
        end
        else
        begin
            add_text("};");
            push_char(CHR_NEWLINE);
            // text after the image is complete is ignored
            if (trailing)
            begin
                add_token(base_digits);
                push_eof();
            end
        end
    endfunction

    // ------------------------------------------------------------------
    // sequencing
    // ------------------------------------------------------------------

    // block idle: nothing queued or held, every byte back, then settle
    task automatic wait_idle();
        do
        begin
            @(posedge clk);
            #1;
        end
        while (char_stream.size() != 0 || char_bus.valid || draining
               || expected_bytes.size() != 0);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_reg(input cfg_index_t idx, input logic [CFG_DATA_W-1:0] value);
        @(posedge clk);
        cfg_write_enable <= 1'b1;
        cfg_index        <= idx;
        cfg_data         <= value;
        @(posedge clk);
        cfg_write_enable <= 1'b0;
    endtask

    task automatic run_image_phase(input int phase_no);
        logic [DIM_W-1:0] w;
        logic [DIM_W-1:0] h;
        logic             fmt;
        int               kind;
        int               row_len;
        int               ntok;
        int               ending;
        kind = (phase_no < 5) ? phase_no : $urandom_range(0, 24);
        fmt  = 1'($urandom_range(0, 1));
        case (kind)
            0:
            begin
                w = 12'd4095;
                h = 12'd4095;
            end
            1:
            begin
                w = 12'd0;
                h = DIM_W'($urandom_range(1, 8));
            end
            2:
            begin
                w = DIM_W'($urandom_range(1, 64));
                h = 12'd0;
            end
            3:
            begin
                // x10 with padded rows: every word loses its high byte
                w   = 12'd8;
                h   = 12'd2;
                fmt = 1'b1;
            end
            4:
            begin
                w   = 12'd1;
                h   = 12'd1;
                fmt = 1'b0;
            end
            default:
            begin
                w = DIM_W'($urandom_range(1, 48));
                h = DIM_W'($urandom_range(1, 5));
            end
        endcase

        wait_idle();
        write_reg(CFG_IMAGE_WIDTH, w);
        write_reg(CFG_IMAGE_HEIGHT, h);
        write_reg(CFG_OLD_WORD_FORMAT, {{(CFG_DATA_W-1){1'b0}}, fmt});
        set_image_setup(w, h, fmt);
        image_setups++;
        steady_send = ($urandom_range(0, 3) == 0);
        steady_recv = ($urandom_range(0, 3) == 0);

        row_len = (int'(w) + 7) / 8;
        ntok    = fmt ? int'(h) * ((row_len + 1) / 2) : int'(h) * row_len;
        if (kind <= 2)
        begin
            // huge or empty image: a few tokens, then the file ends
            add_body($urandom_range(3, 20), fmt ? 4 : 2, 1'b1, 1'b0);
        end
        else
        begin
            ending = $urandom_range(0, 9);
            if (ending < 7)
            begin
                add_body(ntok, fmt ? 4 : 2, 1'b0, ending < 3);
            end
            else
            begin
                add_body($urandom_range(0, ntok - 1), fmt ? 4 : 2, 1'b1, 1'b0);
            end
        end
    endtask

    // ------------------------------------------------------------------
    // character driver: one transfer per accepted item, random gaps
    // ------------------------------------------------------------------

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55)
        begin
            return 0;
        end
        if (r < 90)
        begin
            return $urandom_range(1, 3);
        end
        return $urandom_range(8, 40);
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            char_bus.valid       <= 1'b0;
            char_bus.char_code   <= '0;
            char_bus.end_of_file <= 1'b0;
            send_gap = 0;
            draining = 1'b0;
        end
        else if (!char_bus.valid || char_bus.ready)
        begin
            // the previous item, if any, was transferred at this edge
            if (draining)
            begin
                if (expected_bytes.size() == 0)
                begin
                    draining = 1'b0;
                end
                char_bus.valid <= 1'b0;
            end
            else if (send_gap > 0)
            begin
                send_gap--;
                char_bus.valid <= 1'b0;
            end
            else if (char_stream.size() > 0)
            begin
                next_char = char_stream.pop_front();
                if (next_char.pause)
                begin
                    draining = 1'b1;
                    char_bus.valid <= 1'b0;
                end
                else
                begin
                    char_bus.valid       <= 1'b1;
                    char_bus.char_code   <= next_char.code;
                    char_bus.end_of_file <= next_char.eof;
                    send_gap = steady_send ? 0 : pick_gap();
                end
            end
            else
            begin
                char_bus.valid <= 1'b0;
            end
        end
    end

    // byte receiver: stalls of random length, none in steady phases
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            byte_bus.ready <= 1'b0;
            recv_stall = 0;
        end
        else if (recv_stall > 0)
        begin
            recv_stall--;
            byte_bus.ready <= 1'b0;
        end
        else
        begin
            byte_bus.ready <= 1'b1;
            if (!steady_recv && $urandom_range(0, 2) == 0)
            begin
                recv_stall = pick_gap();
            end
        end
    end

    // ------------------------------------------------------------------
    // monitor: predict on character transfers, check byte transfers
    // ------------------------------------------------------------------

    function automatic void report_mismatch(input string what, input result_t want,
                                            input result_t got);
        mismatches++;
        if (mismatches <= REPORT_LIMIT)
        begin
            $display("mismatch (%s): expected byte %02h last %0b truncated %0b",
                     what, want.pixel_byte, want.last_byte, want.truncated);
            $display("    got byte %02h last %0b truncated %0b",
                     got.pixel_byte, got.last_byte, got.truncated);
        end
    endfunction

    function automatic void check_byte();
        result_t got;
        result_t want;
        got.pixel_byte = byte_bus.pixel_byte;
        got.last_byte  = byte_bus.last_byte;
        got.truncated  = byte_bus.truncated;
        bytes_checked++;
        if (got.last_byte === 1'b1)
        begin
            lasts_seen++;
        end
        if (got.truncated === 1'b1)
        begin
            truncs_seen++;
        end
        if (expected_bytes.size() == 0)
        begin
            report_mismatch("no byte pending", '0, got);
            return;
        end
        want = expected_bytes.pop_front();
        if (got.pixel_byte !== want.pixel_byte || got.last_byte !== want.last_byte
            || got.truncated !== want.truncated)
        begin
            report_mismatch("wrong byte", want, got);
        end
    endfunction

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (char_bus.valid && char_bus.ready)
            begin
                decode_char(char_bus.char_code, char_bus.end_of_file);
                chars_taken++;
            end
            if (byte_bus.valid && byte_bus.ready)
            begin
                check_byte();
            end
        end
    end

    // watchdog: too long without any transfer or register write
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((char_bus.valid && char_bus.ready) || (byte_bus.valid && byte_bus.ready)
                || cfg_write_enable)
            begin
                idle_cycles = 0;
            end
            else
            begin
                idle_cycles++;
            end
            if (idle_cycles >= WATCHDOG_LIMIT)
            begin
                $display("watchdog: no transfer for %0d cycles, %0d bytes still pending",
                         idle_cycles, expected_bytes.size());
                $display("tb: FAIL");
                $finish;
            end
        end
    end

    // ------------------------------------------------------------------
    // main sequence
    // ------------------------------------------------------------------

    initial
    begin
        int random_start;
        int phase_no;
        rst_n                = 1'b0;
        char_bus.valid       = 1'b0;
        char_bus.char_code   = '0;
        char_bus.end_of_file = 1'b0;
        byte_bus.ready       = 1'b0;
        cfg_write_enable     = 1'b0;
        cfg_index            = CFG_IMAGE_WIDTH;
        cfg_data             = '0;
        steady_send          = 1'b0;
        steady_recv          = 1'b0;
        items_queued         = 0;
        chars_taken          = 0;
        bytes_checked        = 0;
        lasts_seen           = 0;
        truncs_seen          = 0;
        image_setups         = 0;
        mismatches           = 0;
        idle_cycles          = 0;
        // reset setup: 16 by 16, x11 bytes
        set_image_setup(WIDTH_RESET, HEIGHT_RESET, 1'b0);
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;

        // directed: prefixed token, then hold until its byte is back
        add_text("0x9F,");
        push_pause();
        // delimiter with no digit, mixed case, skipped carriage return
        add_text(" aB");
        push_char(CHR_CR);
        // tab, long token, newline, closing brace, skipped letter
        add_text("\t12345\n0}g");
        push_char(8'hff);
        push_char(8'h00);
        // end of file inside a token, then a second one that is ignored
        add_text("7");
        push_eof();
        push_eof();

        random_start = items_queued;
        phase_no     = 0;
        while (items_queued - random_start < RANDOM_ITEMS)
        begin
            run_image_phase(phase_no);
            phase_no++;
        end

        wait_idle();
        repeat (SETTLE_CYCLES) @(posedge clk);

        $display("run covered %0d characters, %0d image setups, sizes 0 to 4095, x10 and x11",
                 chars_taken, image_setups);
        $display("checked %0d bytes: %0d image ends, %0d truncated, %0d mismatches",
                 bytes_checked, lasts_seen, truncs_seen, mismatches);
        if (mismatches == 0 && expected_bytes.size() == 0)
        begin
            $display("tb: PASS");
        end
        else
        begin
            $display("tb: FAIL");
        end
        $finish;
    end

endmodule

`default_nettype wire
